FILE: design/epoch_seconds_to_calendar_assert.svh
// Assertion macros for the epoch-to-calendar block.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ESC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ESC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/esc_pkg.sv
package esc_pkg;

  // Divisors pre-shifted to the top quotient bit of each restoring division
  localparam logic [31:0] DivDayTop  = 32'd2831155200;  // 86400 << 15
  localparam logic [31:0] DivHourTop = 32'd57600;       // 3600 << 4
  localparam logic [31:0] DivMinTop  = 32'd1920;        // 60 << 5

  localparam logic [3:0]  DayBits    = 4'd15;
  localparam logic [3:0]  HourBits   = 4'd4;
  localparam logic [3:0]  MinBits    = 4'd5;

  localparam logic [11:0] EpochYear  = 12'd1970;
  localparam logic [3:0]  LastMonth  = 4'd11;
  localparam logic [8:0]  YearLenStd = 9'd365;
  localparam logic [8:0]  YearLenLeap = 9'd366;

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic [11:0] year;
    logic [8:0]  year_day;
    logic [3:0]  month;
    logic [4:0]  month_day;
  } esc_result_t;

  typedef struct packed {
    logic idle;
    logic done;
  } esc_stat_t;

  // Reachable years are 1970..2106: the only centuries are 2000 (leap) and 2100 (not)
  function automatic logic leap_of(input logic [11:0] year);
    leap_of = (year[1:0] == 2'b00) && (year != 12'd2100);
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
    case (mon)
      4'd0:    month_len = 5'd31;
      4'd1:    month_len = leap ? 5'd29 : 5'd28;
      4'd2:    month_len = 5'd31;
      4'd3:    month_len = 5'd30;
      4'd4:    month_len = 5'd31;
      4'd5:    month_len = 5'd30;
      4'd6:    month_len = 5'd31;
      4'd7:    month_len = 5'd31;
      4'd8:    month_len = 5'd30;
      4'd9:    month_len = 5'd31;
      4'd10:   month_len = 5'd30;
      default: month_len = 5'd31;
    endcase
  endfunction

endpackage

FILE: design/esc_in_if.sv
interface esc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] utc_seconds;

  modport source (output valid, output utc_seconds, input ready);
  modport sink (input valid, input utc_seconds, output ready);
endinterface

FILE: design/esc_out_if.sv
interface esc_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [2:0]  weekday;
  logic [11:0] year;
  logic [8:0]  year_day;
  logic [3:0]  month;
  logic [4:0]  month_day;

  modport source (output valid, output hour, output minute, output second, output weekday,
                  output year, output year_day, output month, output month_day, input ready);
  modport sink (input valid, input hour, input minute, input second, input weekday,
                input year, input year_day, input month, input month_day, output ready);
endinterface

FILE: design/esc_core.sv
module esc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [31:0]         time_i,
  input  logic                take_i,
  output esc_pkg::esc_stat_t   stat_o,
  output esc_pkg::esc_result_t res_o
);
  import esc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DAYS  = 3'd1;
  localparam logic [2:0] S_HOUR  = 3'd2;
  localparam logic [2:0] S_MIN   = 3'd3;
  localparam logic [2:0] S_YEAR  = 3'd4;
  localparam logic [2:0] S_MONTH = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] div_q, div_d;
  logic [15:0] quo_q, quo_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [2:0]  wk_q, wk_d;
  logic [15:0] days_q, days_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  minute_q, minute_d;
  logic [5:0]  second_q, second_d;
  logic [11:0] year_q, year_d;
  logic [8:0]  yday_q, yday_d;
  logic [3:0]  mon_q, mon_d;

  // shared subtract/compare unit
  logic        leap;
  logic [31:0] sub_op;
  logic [32:0] diff;
  logic        ge;
  logic [3:0]  wk_dbl;

  assign leap = leap_of(year_q);

  always_comb begin
    case (state_q)
      S_YEAR:  sub_op = {23'd0, leap ? YearLenLeap : YearLenStd};
      S_MONTH: sub_op = {27'd0, month_len(leap, mon_q)};
      default: sub_op = div_q;
    endcase
  end

  assign diff   = {1'b0, acc_q} - {1'b0, sub_op};
  assign ge     = ~diff[32];
  // day count mod 7, built as quotient bits arrive MSB first
  assign wk_dbl = {wk_q, ge};

  always_comb begin
    state_d  = state_q;
    acc_d    = acc_q;
    div_d    = div_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    wk_d     = wk_q;
    days_d   = days_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    year_d   = year_q;
    yday_d   = yday_q;
    mon_d    = mon_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          acc_d   = time_i;
          div_d   = DivDayTop;
          cnt_d   = DayBits;
          wk_d    = 3'd0;
          state_d = S_DAYS;
        end
      end
      S_DAYS, S_HOUR, S_MIN: begin
        quo_d = {quo_q[14:0], ge};
        div_d = div_q >> 1;
        cnt_d = cnt_q - 4'd1;
        if (ge) begin
          acc_d = diff[31:0];
        end
        if (state_q == S_DAYS) begin
          wk_d = (wk_dbl >= 4'd7) ? 3'(wk_dbl - 4'd7) : wk_dbl[2:0];
        end
        if (cnt_q == 4'd0) begin
          case (state_q)
            S_DAYS: begin
              days_d  = quo_d;
              div_d   = DivHourTop;
              cnt_d   = HourBits;
              state_d = S_HOUR;
            end
            S_HOUR: begin
              hour_d  = quo_d[4:0];
              div_d   = DivMinTop;
              cnt_d   = MinBits;
              state_d = S_MIN;
            end
            default: begin
              minute_d = quo_d[5:0];
              second_d = ge ? diff[5:0] : acc_q[5:0];
              acc_d    = {16'd0, days_q};
              year_d   = EpochYear;
              state_d  = S_YEAR;
            end
          endcase
        end
      end
      S_YEAR: begin
        if (ge) begin
          acc_d  = diff[31:0];
          year_d = year_q + 12'd1;
        end else begin
          yday_d  = acc_q[8:0];
          mon_d   = 4'd0;
          state_d = S_MONTH;
        end
      end
      S_MONTH: begin
        if (ge && (mon_q != LastMonth)) begin
          acc_d = diff[31:0];
          mon_d = mon_q + 4'd1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    div_q    <= div_d;
    quo_q    <= quo_d;
    cnt_q    <= cnt_d;
    wk_q     <= wk_d;
    days_q   <= days_d;
    hour_q   <= hour_d;
    minute_q <= minute_d;
    second_q <= second_d;
    year_q   <= year_d;
    yday_q   <= yday_d;
    mon_q    <= mon_d;
  end

  assign stat_o.idle = (state_q == S_IDLE);
  assign stat_o.done = (state_q == S_DONE);

  // day 0 was a Thursday
  assign res_o.hour      = hour_q;
  assign res_o.minute    = minute_q;
  assign res_o.second    = second_q;
  assign res_o.weekday   = (wk_q >= 3'd3) ? (wk_q - 3'd3) : (wk_q + 3'd4);
  assign res_o.year      = year_q;
  assign res_o.year_day  = yday_q;
  assign res_o.month     = mon_q;
  assign res_o.month_day = acc_q[4:0] + 5'd1;

endmodule

FILE: design/epoch_seconds_to_calendar.sv
// Channel   Dir  Payload                                    Transfer
// in_i      in   utc_seconds[31:0]                          valid & ready
// out_o     out  hour minute second weekday year            valid & ready
//                year_day month month_day
// apb       in   offset_seconds at byte address 0           psel & penable & pwrite
//
// Per transaction the sequencer loads the sum while idle, then runs the day split,
// the hour and minute splits, the year loop and the month loop, and holds the
// result in its done state; the year loop on the shared subtractor is the longest step.
// in_i.ready is high only while the sequencer is idle; a finished result moves
// to the output register, so a new transaction may start while it waits.
// rst_ni clears the offset register and all control state asynchronously.
`include "epoch_seconds_to_calendar_assert.svh"

module epoch_seconds_to_calendar (
  input  logic        clk_i,
  input  logic        rst_ni,
  esc_in_if.sink      in_i,
  esc_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import esc_pkg::*;

  logic [16:0]  offset_q;
  logic         cfg_wr;
  logic         start;
  logic [31:0]  t_sum;
  logic         take;
  logic         out_valid_q;
  esc_result_t  out_res_q;
  esc_result_t  core_res;
  esc_stat_t    core_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {{15{offset_q[16]}}, offset_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= 17'd0;
    end else if (cfg_wr) begin
      offset_q <= pwdata[16:0];
    end
  end

  // wraps modulo 2^32
  assign t_sum = in_i.utc_seconds + {{15{offset_q[16]}}, offset_q};

  assign in_i.ready = core_stat.idle;
  assign start      = in_i.valid && in_i.ready;
  assign take       = core_stat.done && (!out_valid_q || out_o.ready);

  esc_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .time_i  (t_sum),
    .take_i  (take),
    .stat_o  (core_stat),
    .res_o   (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_res_q <= core_res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.hour      = out_res_q.hour;
  assign out_o.minute    = out_res_q.minute;
  assign out_o.second    = out_res_q.second;
  assign out_o.weekday   = out_res_q.weekday;
  assign out_o.year      = out_res_q.year;
  assign out_o.year_day  = out_res_q.year_day;
  assign out_o.month     = out_res_q.month;
  assign out_o.month_day = out_res_q.month_day;

  `ESC_ASSERT_NEXT(a_busy_after_start, start, !in_i.ready, "input taken while sequencer busy")
  `ESC_ASSERT_NOW(a_no_overwrite, take && out_valid_q, out_o.ready, "pending result overwritten")
  `ESC_ASSERT_NOW(a_fields_in_range, out_valid_q, (out_o.hour <= 5'd23) && (out_o.minute <= 6'd59) && (out_o.second <= 6'd59) && (out_o.weekday <= 3'd6) && (out_o.month <= 4'd11) && (out_o.month_day != 5'd0), "result field out of range")

endmodule
